// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// Each macro takes a label, a clock, an active-low reset, and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/blm_pkg.sv
`default_nettype none

package blm_pkg;

    // Frame geometry
    localparam int BAND_COUNT = 12;
    localparam int BAND_SPAN  = 128;
    localparam int MIDPOINT   = 128;

    // Field widths
    localparam int SAMPLE_W = 8;
    localparam int BAND_W   = 4;
    localparam int LEVEL_W  = 10;
    localparam int GAIN_W   = 8;
    localparam int STEP_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Derived widths
    localparam int ADDR_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam int SLOT_W = (BAND_SPAN > 1) ? $clog2(BAND_SPAN) : 1;
    localparam int CNT_W  = $clog2(BAND_SPAN + 1);
    localparam int DEV_W  = $clog2(MIDPOINT + 1);
    localparam int SUM_W  = $clog2(MIDPOINT * BAND_SPAN + 1);
    localparam int MEAN_W = DEV_W;
    localparam int PROD_W = MEAN_W + GAIN_W;
    localparam int MIX_W  = LEVEL_W + 2;

    // Divide by three as multiply by reciprocal, exact for values below 3 * 2^LEVEL_W
    localparam int DIV3_SHIFT = MIX_W + 1;
    localparam int DIV3_MUL   = (1 << DIV3_SHIFT) / 3 + 1;
    localparam int DIV3_MUL_W = DIV3_SHIFT;
    localparam int DIV3_PROD_W = MIX_W + DIV3_MUL_W;

    // Register reset values
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(24);
    localparam logic [LEVEL_W-1:0] LIMIT_RESET = LEVEL_W'(1000);
    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(4);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LIMIT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP  = CFG_IDX_W'(2);

    // Request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_DECAY  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_TARGET,
        ST_MIX,
        ST_BAND_WR,
        ST_DECAY_RD,
        ST_DECAY_WR
    } state_t;

    // Divider control and status
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

`default_nettype wire

// File: hdl/blm_in_if.sv
`default_nettype none

interface blm_in_if;
    import blm_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [SAMPLE_W-1:0] sample;
    logic                sample_present;

    modport source (output valid, output req_type, output sample, output sample_present,
                    input ready);
    modport sink   (input valid, input req_type, input sample, input sample_present,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/blm_out_if.sv
`default_nettype none

interface blm_out_if;
    import blm_pkg::*;

    logic               valid;
    logic               ready;
    logic [BAND_W-1:0]  band;
    logic [LEVEL_W-1:0] level;
    logic               last;

    modport source (output valid, output band, output level, output last, input ready);
    modport sink   (input valid, input band, input level, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/blm_cfg_if.sv
`default_nettype none

interface blm_cfg_if;
    import blm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/band_level_meter_unit.sv
`default_nettype none

// Band level meter. Takes one sample slot or decay tick per input beat and keeps
// twelve smoothed bar levels in a small synchronous RAM. A sample slot that does
// not close its band is accumulated and the unit stays ready for the next slot.
// The slot that closes a band starts a bit-serial mean divider, one quotient bit
// at a time, followed by gain, clamp, read of the old bar, smoothing and write-back,
// after which one result beat is issued. A decay tick walks the bar RAM, one read
// and one write per bar, and issues twelve result beats. Result beats wait in an
// output register, so the sample side keeps flowing while a result stalls; the
// next item is taken once the current one has left the sequencer. The bar store
// reads as zero after reset by way of per-bar valid flags, so there is no clearing
// pass. Registers must be written through the config channel only while the unit
// is idle, which the unit does not enforce; indexes past decay_step are ignored.

module band_level_meter_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    blm_in_if.sink    samples,
    blm_out_if.source results,
    blm_cfg_if.sink   cfg
);
    import blm_pkg::*;

    `include "assert_macros.svh"

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]  gain_reg;
    logic [LEVEL_W-1:0] limit_reg;
    logic [STEP_W-1:0]  step_reg;

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [ADDR_W-1:0]  band_reg, band_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [MEAN_W-1:0]  mean_reg, mean_next;
    logic [LEVEL_W-1:0] target_reg, target_next;
    logic [MIX_W-1:0]   mix_reg, mix_next;
    logic [BAND_COUNT-1:0] bar_valid_reg;

    logic               out_valid_reg, out_valid_next;
    logic [BAND_W-1:0]  out_band_reg, out_band_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;
    logic               out_last_reg, out_last_next;

    logic               in_fire;
    logic               out_free;
    logic [DEV_W-1:0]   dev;
    logic [SUM_W-1:0]   sum_add;
    logic [CNT_W-1:0]   cnt_add;
    logic               band_end;

    div_ctl_t           div_ctl;
    div_sts_t           div_sts;
    logic [MEAN_W-1:0]  div_quo;

    logic               ram_we;
    logic               ram_re;
    logic [LEVEL_W-1:0] ram_wdata;
    logic [LEVEL_W-1:0] ram_rdata;

    logic [LEVEL_W-1:0]     old_level;
    logic [PROD_W-1:0]      gain_prod;
    logic [LEVEL_W-1:0]     target_clamped;
    logic [DIV3_PROD_W-1:0] div3_prod;
    logic [LEVEL_W-1:0]     smooth_level;
    logic [LEVEL_W-1:0]     decayed_level;
    logic                   decay_last;

    // Mean deviation divider
    blm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (sum_add),
        .divisor  (cnt_add),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    // Bar level store
    blm_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (BAND_COUNT)
    ) u_bar_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Handshake
    assign samples.ready = (state_reg == ST_IDLE);
    assign in_fire       = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || results.ready;
    assign cfg.ready     = 1'b1;

    assign results.valid = out_valid_reg;
    assign results.band  = out_band_reg;
    assign results.level = out_level_reg;
    assign results.last  = out_last_reg;

    // Accumulate deviation of the incoming slot
    always_comb
    begin
        if (samples.sample >= SAMPLE_W'(MIDPOINT))
        begin
            dev = DEV_W'(samples.sample - SAMPLE_W'(MIDPOINT));
        end
        else
        begin
            dev = DEV_W'(DEV_W'(MIDPOINT) - DEV_W'(samples.sample));
        end
        sum_add  = samples.sample_present ? (sum_reg + SUM_W'(dev)) : sum_reg;
        cnt_add  = samples.sample_present ? (cnt_reg + CNT_W'(1)) : cnt_reg;
        band_end = (slot_reg == SLOT_W'(BAND_SPAN - 1));
    end

    // Bar arithmetic
    always_comb
    begin
        old_level = bar_valid_reg[addr_reg] ? ram_rdata : '0;
        gain_prod = PROD_W'(mean_reg) * PROD_W'(gain_reg);
        if (gain_prod > PROD_W'(limit_reg))
        begin
            target_clamped = limit_reg;
        end
        else
        begin
            target_clamped = gain_prod[LEVEL_W-1:0];
        end
        div3_prod    = DIV3_PROD_W'(mix_reg) * DIV3_PROD_W'(DIV3_MUL);
        smooth_level = div3_prod[DIV3_SHIFT +: LEVEL_W];
        if (old_level > LEVEL_W'(step_reg))
        begin
            decayed_level = old_level - LEVEL_W'(step_reg);
        end
        else
        begin
            decayed_level = old_level;
        end
        decay_last = (addr_reg == ADDR_W'(BAND_COUNT - 1));
    end

    // Sequencer next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        band_next      = band_reg;
        addr_next      = addr_reg;
        mean_next      = mean_reg;
        target_next    = target_reg;
        mix_next       = mix_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_band_next  = out_band_reg;
        out_level_next = out_level_reg;
        out_last_next  = out_last_reg;
        div_ctl.start  = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wdata      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (samples.req_type == REQ_DECAY)
                    begin
                        addr_next  = '0;
                        state_next = ST_DECAY_RD;
                    end
                    else if (band_end)
                    begin
                        div_ctl.start = 1'b1;
                        sum_next      = '0;
                        cnt_next      = '0;
                        slot_next     = '0;
                        addr_next     = band_reg;
                        if (band_reg == ADDR_W'(BAND_COUNT - 1))
                        begin
                            band_next = '0;
                        end
                        else
                        begin
                            band_next = band_reg + ADDR_W'(1);
                        end
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        sum_next  = sum_add;
                        cnt_next  = cnt_add;
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end

            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    mean_next  = div_quo;
                    state_next = ST_TARGET;
                end
            end

            ST_TARGET:
            begin
                target_next = target_clamped;
                ram_re      = 1'b1;
                state_next  = ST_MIX;
            end

            ST_MIX:
            begin
                mix_next   = MIX_W'({old_level, 1'b0}) + MIX_W'(target_reg);
                state_next = ST_BAND_WR;
            end

            ST_BAND_WR:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = smooth_level;
                    out_valid_next = 1'b1;
                    out_band_next  = BAND_W'(addr_reg);
                    out_level_next = smooth_level;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_DECAY_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_DECAY_WR;
            end

            ST_DECAY_WR:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = decayed_level;
                    out_valid_next = 1'b1;
                    out_band_next  = BAND_W'(addr_reg);
                    out_level_next = decayed_level;
                    out_last_next  = decay_last;
                    if (decay_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg + ADDR_W'(1);
                        state_next = ST_DECAY_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            slot_reg      <= '0;
            band_reg      <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            bar_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            slot_reg      <= slot_next;
            band_reg      <= band_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                bar_valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mean_reg      <= mean_next;
        target_reg    <= target_next;
        mix_reg       <= mix_next;
        out_band_reg  <= out_band_next;
        out_level_reg <= out_level_next;
        out_last_reg  <= out_last_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            limit_reg <= LIMIT_RESET;
            step_reg  <= STEP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_LEVEL_GAIN:  gain_reg  <= cfg.data[GAIN_W-1:0];
                REG_LEVEL_LIMIT: limit_reg <= cfg.data[LEVEL_W-1:0];
                REG_DECAY_STEP:  step_reg  <= cfg.data[STEP_W-1:0];
                default:         ;
            endcase
        end
    end

    // Checks
    `ASSERT_IMPLIES(a_write_loads_out, clk, rst_n, ram_we, out_free && out_valid_next)
    `ASSERT_IMPLIES(a_div_done_in_div, clk, rst_n, div_sts.done, state_reg == ST_DIV)
    `ASSERT_IMPLIES(a_addr_in_range, clk, rst_n, ram_re || ram_we, addr_reg <= ADDR_W'(BAND_COUNT - 1))
    `ASSERT_NEXT(a_start_busy, clk, rst_n, div_ctl.start, div_sts.busy && state_reg == ST_DIV)

endmodule

`default_nettype wire

// File: hdl/blm_ram.sv
`default_nettype none

module blm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/blm_div.sv
`default_nettype none

module blm_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire blm_pkg::div_ctl_t        ctl,
    input  wire logic [blm_pkg::SUM_W-1:0]  dividend,
    input  wire logic [blm_pkg::CNT_W-1:0]  divisor,
    output blm_pkg::div_sts_t             sts,
    output logic      [blm_pkg::MEAN_W-1:0] quotient
);
    import blm_pkg::*;

    localparam int ITER_W = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              zero_reg, zero_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W:0]    trial;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        if (ctl.start)
        begin
            busy_next = 1'b1;
            zero_next = (divisor == '0);
            iter_next = ITER_W'(SUM_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next    = CNT_W'(trial - {1'b0, dsr_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
            iter_next = iter_reg - ITER_W'(1);
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = zero_reg ? '0 : quo_reg[MEAN_W-1:0];

endmodule

`default_nettype wire
